// File: rtl/sgi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sgi_pkg;

  localparam int COORD_BITS_DEF = 16;

  localparam logic [2:0] ST_NONE  = 3'd0;
  localparam logic [2:0] ST_HIT   = 3'd1;
  localparam logic [2:0] ST_A_PT  = 3'd2;
  localparam logic [2:0] ST_C_PT  = 3'd3;
  localparam logic [2:0] ST_EQUAL = 3'd4;

  typedef struct packed {
    logic       vld;
    logic [2:0] status;
  } ctl_t;

endpackage
`default_nettype wire

// File: rtl/sgi_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sgi_in_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] a_x;
  logic signed [W-1:0] a_y;
  logic signed [W-1:0] b_x;
  logic signed [W-1:0] b_y;
  logic signed [W-1:0] c_x;
  logic signed [W-1:0] c_y;
  logic signed [W-1:0] d_x;
  logic signed [W-1:0] d_y;

  modport source (output valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, input ready);
  modport sink (input valid, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y, output ready);
endinterface
`default_nettype wire

// File: rtl/sgi_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sgi_out_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic [2:0]          status;
  logic signed [W-1:0] cross_x;
  logic signed [W-1:0] cross_y;

  modport source (output valid, status, cross_x, cross_y, input ready);
  modport sink (input valid, status, cross_x, cross_y, output ready);
endinterface
`default_nettype wire

// File: rtl/sgi_div.sv
`timescale 1ns / 1ps
`default_nettype none
module sgi_div #(
  parameter int N  = 16,
  parameter int DW = 35,
  parameter int NW = 53,
  parameter int QW = 18
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   en,
  input  sgi_pkg::ctl_t         ctl_i,
  input  wire  [DW-1:0]         den_i,
  input  wire  [NW-1:0]         numx_i,
  input  wire  [NW-1:0]         numy_i,
  input  wire                   negx_i,
  input  wire                   negy_i,
  output sgi_pkg::ctl_t         ctl_o,
  output logic [N-1:0]          qx_o,
  output logic [N-1:0]          qy_o
);
  import sgi_pkg::*;

  logic [DW-1:0] remx0, remy0;

  ctl_t          ctl_r  [1:QW];
  logic [DW-1:0] den_r  [1:QW];
  logic [DW-1:0] remx_r [1:QW];
  logic [DW-1:0] remy_r [1:QW];
  logic [QW-1:0] lox_r  [1:QW];
  logic [QW-1:0] loy_r  [1:QW];
  logic          negx_r [1:QW];
  logic          negy_r [1:QW];

  logic [QW-1:0] qx_full, qy_full;

  generate
    if (NW > QW) begin : g_hi
      assign remx0 = DW'(numx_i[NW-1:QW]);
      assign remy0 = DW'(numy_i[NW-1:QW]);
    end else begin : g_nohi
      assign remx0 = '0;
      assign remy0 = '0;
    end
  endgenerate

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      ctl_t          ctl_p;
      logic [DW-1:0] den_p, remx_p, remy_p;
      logic [QW-1:0] lox_p, loy_p;
      logic          negx_p, negy_p;
      logic [DW:0]   tx, ty, dx, dy;
      logic          gex, gey;
      logic [DW-1:0] remx_nxt, remy_nxt;
      logic [QW-1:0] lox_nxt, loy_nxt;

      if (k == 0) begin : g_first
        assign ctl_p  = ctl_i;
        assign den_p  = den_i;
        assign remx_p = remx0;
        assign remy_p = remy0;
        assign lox_p  = numx_i[QW-1:0];
        assign loy_p  = numy_i[QW-1:0];
        assign negx_p = negx_i;
        assign negy_p = negy_i;
      end else begin : g_next
        assign ctl_p  = ctl_r[k];
        assign den_p  = den_r[k];
        assign remx_p = remx_r[k];
        assign remy_p = remy_r[k];
        assign lox_p  = lox_r[k];
        assign loy_p  = loy_r[k];
        assign negx_p = negx_r[k];
        assign negy_p = negy_r[k];
      end

      assign tx       = {remx_p, lox_p[QW-1]};
      assign ty       = {remy_p, loy_p[QW-1]};
      assign dx       = tx - {1'b0, den_p};
      assign dy       = ty - {1'b0, den_p};
      assign gex      = tx >= {1'b0, den_p};
      assign gey      = ty >= {1'b0, den_p};
      assign remx_nxt = gex ? dx[DW-1:0] : tx[DW-1:0];
      assign remy_nxt = gey ? dy[DW-1:0] : ty[DW-1:0];
      assign lox_nxt  = {lox_p[QW-2:0], gex};
      assign loy_nxt  = {loy_p[QW-2:0], gey};

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctl_r[k+1].vld <= 1'b0;
        end else if (en) begin
          ctl_r[k+1].vld <= ctl_p.vld;
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ctl_r[k+1].status <= ctl_p.status;
          den_r[k+1]        <= den_p;
          remx_r[k+1]       <= remx_nxt;
          remy_r[k+1]       <= remy_nxt;
          lox_r[k+1]        <= lox_nxt;
          loy_r[k+1]        <= loy_nxt;
          negx_r[k+1]       <= negx_p;
          negy_r[k+1]       <= negy_p;
        end
      end
    end
  endgenerate

  assign qx_full = negx_r[QW] ? (~lox_r[QW] + 1'b1) : lox_r[QW];
  assign qy_full = negy_r[QW] ? (~loy_r[QW] + 1'b1) : loy_r[QW];
  assign qx_o    = qx_full[N-1:0];
  assign qy_o    = qy_full[N-1:0];
  assign ctl_o   = ctl_r[QW];

endmodule
`default_nettype wire

// File: rtl/segment_intersection_2d_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// path: input stages, then the one-quotient-bit-per-stage divider (QW = COORD_BITS + 2
// for COORD_BITS up to 20, else QW = NW), then the output register
// throughput: one segment pair per cycle; the whole pipeline holds while the result waits
// reset: synchronous active low, clears all stage valid bits, payload is not reset
module segment_intersection_2d_unit #(
  parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
  input wire        clk,
  input wire        rst_n,
  sgi_in_if.sink    in_ch,
  sgi_out_if.source out_ch
);
  import sgi_pkg::*;

  localparam int N  = COORD_BITS;
  localparam int D1 = N + 1;
  localparam int PW = 2 * D1;
  localparam int DF = PW + 1;
  localparam int DW = (DF > 64) ? 64 : DF;
  localparam int TW = DW + D1;
  localparam int NF = TW + 1;
  localparam int NW = (NF > 64) ? 64 : NF;
  localparam int QW = (N <= 20) ? N + 2 : NW;

  function automatic logic unit_range(input logic signed [63:0] num,
                                      input logic signed [63:0] den);
    logic signed [63:0] n;
    logic signed [63:0] d;
    begin
      n = (den < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      return (n >= 0) && (n <= d);
    end
  endfunction

  logic en;
  logic out_vld_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // stage 1: differences and degenerate checks
  logic                 v1_r;
  logic [2:0]           st1_nxt, st1_r;
  logic signed [D1-1:0] ux_r, uy_r, vx_r, vy_r, ex_r, ey_r, wx_r, wy_r, fx_r, fy_r;
  logic signed [N-1:0]  ax1_r, ay1_r, bx1_r, by1_r, cx1_r, cy1_r;

  always_comb begin
    if (in_ch.a_x == in_ch.b_x && in_ch.a_y == in_ch.b_y) begin
      st1_nxt = ST_A_PT;
    end else if (in_ch.c_x == in_ch.d_x && in_ch.c_y == in_ch.d_y) begin
      st1_nxt = ST_C_PT;
    end else if (in_ch.a_x == in_ch.c_x && in_ch.a_y == in_ch.c_y &&
                 in_ch.b_x == in_ch.d_x && in_ch.b_y == in_ch.d_y) begin
      st1_nxt = ST_EQUAL;
    end else begin
      st1_nxt = ST_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st1_r <= st1_nxt;
      ux_r  <= D1'(in_ch.b_x) - D1'(in_ch.a_x);
      uy_r  <= D1'(in_ch.b_y) - D1'(in_ch.a_y);
      vx_r  <= D1'(in_ch.c_x) - D1'(in_ch.d_x);
      vy_r  <= D1'(in_ch.c_y) - D1'(in_ch.d_y);
      ex_r  <= D1'(in_ch.c_x) - D1'(in_ch.a_x);
      ey_r  <= D1'(in_ch.c_y) - D1'(in_ch.a_y);
      wx_r  <= D1'(in_ch.d_x) - D1'(in_ch.c_x);
      wy_r  <= D1'(in_ch.d_y) - D1'(in_ch.c_y);
      fx_r  <= D1'(in_ch.d_x) - D1'(in_ch.a_x);
      fy_r  <= D1'(in_ch.d_y) - D1'(in_ch.a_y);
      ax1_r <= in_ch.a_x;
      ay1_r <= in_ch.a_y;
      bx1_r <= in_ch.b_x;
      by1_r <= in_ch.b_y;
      cx1_r <= in_ch.c_x;
      cy1_r <= in_ch.c_y;
    end
  end

  // stage 2: cross products, collinear position tests
  logic                 v2_r;
  logic [2:0]           st2_r;
  logic signed [PW-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  logic signed [D1-1:0] cden, cpos, dpos;
  logic                 colc_r, cold_r;
  logic signed [D1-1:0] wx2_r, wy2_r;
  logic signed [N-1:0]  ax2_r, ay2_r, bx2_r, by2_r, cx2_r, cy2_r;

  assign cden = (ux_r != 0) ? ux_r : uy_r;
  assign cpos = (ux_r != 0) ? ex_r : ey_r;
  assign dpos = (ux_r != 0) ? fx_r : fy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st2_r  <= st1_r;
      m0_r   <= PW'(vy_r) * PW'(ux_r);
      m1_r   <= PW'(vx_r) * PW'(uy_r);
      m2_r   <= PW'(ey_r) * PW'(ux_r);
      m3_r   <= PW'(uy_r) * PW'(ex_r);
      m4_r   <= PW'(ex_r) * PW'(vy_r);
      m5_r   <= PW'(vx_r) * PW'(ey_r);
      colc_r <= unit_range(64'(cpos), 64'(cden));
      cold_r <= unit_range(64'(dpos), 64'(cden));
      wx2_r  <= wx_r;
      wy2_r  <= wy_r;
      ax2_r  <= ax1_r;
      ay2_r  <= ay1_r;
      bx2_r  <= bx1_r;
      by2_r  <= by1_r;
      cx2_r  <= cx1_r;
      cy2_r  <= cy1_r;
    end
  end

  // stage 3: determinant and Cramer numerators
  logic                 v3_r;
  logic [2:0]           st3_r;
  logic signed [DF-1:0] det_f, sn_f, tn_f;
  logic signed [DW-1:0] det_r, sn_r, tn_r;
  logic                 colc3_r, cold3_r;
  logic signed [D1-1:0] wx3_r, wy3_r;
  logic signed [N-1:0]  ax3_r, ay3_r, bx3_r, by3_r, cx3_r, cy3_r;

  assign det_f = DF'(m0_r) - DF'(m1_r);
  assign sn_f  = DF'(m2_r) - DF'(m3_r);
  assign tn_f  = DF'(m4_r) - DF'(m5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st3_r   <= st2_r;
      det_r   <= det_f[DW-1:0];
      sn_r    <= sn_f[DW-1:0];
      tn_r    <= tn_f[DW-1:0];
      colc3_r <= colc_r;
      cold3_r <= cold_r;
      wx3_r   <= wx2_r;
      wy3_r   <= wy2_r;
      ax3_r   <= ax2_r;
      ay3_r   <= ay2_r;
      bx3_r   <= bx2_r;
      by3_r   <= by2_r;
      cx3_r   <= cx2_r;
      cy3_r   <= cy2_r;
    end
  end

  // stage 4: decision and point numerator products
  logic                 v4_r;
  logic [2:0]           st4_nxt, st4_r;
  logic signed [TW-1:0] px1_nxt, px2_nxt, py1_nxt, py2_nxt;
  logic signed [TW-1:0] px1_r, px2_r, py1_r, py2_r;
  logic signed [DW-1:0] den4_nxt, den4_r;

  always_comb begin
    st4_nxt  = st3_r;
    px1_nxt  = '0;
    px2_nxt  = '0;
    py1_nxt  = '0;
    py2_nxt  = '0;
    den4_nxt = DW'(1);
    if (st3_r == ST_NONE) begin
      if (det_r != 0) begin
        if (unit_range(64'(sn_r), 64'(det_r)) && unit_range(64'(tn_r), 64'(det_r))) begin
          st4_nxt  = ST_HIT;
          px1_nxt  = TW'(cx3_r) * TW'(det_r);
          px2_nxt  = TW'(sn_r) * TW'(wx3_r);
          py1_nxt  = TW'(cy3_r) * TW'(det_r);
          py2_nxt  = TW'(sn_r) * TW'(wy3_r);
          den4_nxt = det_r;
        end
      end else if (sn_r == 0) begin
        if (colc3_r) begin
          st4_nxt = ST_HIT;
          px1_nxt = TW'(bx3_r);
          py1_nxt = TW'(by3_r);
        end else if (cold3_r) begin
          st4_nxt = ST_HIT;
          px1_nxt = TW'(ax3_r);
          py1_nxt = TW'(ay3_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st4_r  <= st4_nxt;
      px1_r  <= px1_nxt;
      px2_r  <= px2_nxt;
      py1_r  <= py1_nxt;
      py2_r  <= py2_nxt;
      den4_r <= den4_nxt;
    end
  end

  // stage 5: numerator sums, magnitudes and quotient signs
  logic                 v5_r;
  logic [2:0]           st5_r;
  logic signed [NF-1:0] nx_f, ny_f;
  logic signed [NW-1:0] nx, ny;
  logic [NW-1:0]        magx_nxt, magy_nxt, magx_r, magy_r;
  logic [DW-1:0]        magd_nxt, magd_r;
  logic                 negx_r, negy_r;

  assign nx_f     = NF'(px1_r) + NF'(px2_r);
  assign ny_f     = NF'(py1_r) + NF'(py2_r);
  assign nx       = nx_f[NW-1:0];
  assign ny       = ny_f[NW-1:0];
  assign magx_nxt = nx[NW-1] ? (~nx + 1'b1) : nx;
  assign magy_nxt = ny[NW-1] ? (~ny + 1'b1) : ny;
  assign magd_nxt = den4_r[DW-1] ? (~den4_r + 1'b1) : den4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st5_r  <= st4_r;
      magx_r <= magx_nxt;
      magy_r <= magy_nxt;
      magd_r <= magd_nxt;
      negx_r <= nx[NW-1] ^ den4_r[DW-1];
      negy_r <= ny[NW-1] ^ den4_r[DW-1];
    end
  end

  // divider pipeline
  ctl_t         ctl5, ctl_q;
  logic [N-1:0] qx, qy;

  assign ctl5.vld    = v5_r;
  assign ctl5.status = st5_r;

  sgi_div #(
    .N  (N),
    .DW (DW),
    .NW (NW),
    .QW (QW)
  ) u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .ctl_i  (ctl5),
    .den_i  (magd_r),
    .numx_i (magx_r),
    .numy_i (magy_r),
    .negx_i (negx_r),
    .negy_i (negy_r),
    .ctl_o  (ctl_q),
    .qx_o   (qx),
    .qy_o   (qy)
  );

  // output register
  logic [2:0]   out_st_r;
  logic [N-1:0] out_x_r, out_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl_q.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_st_r <= ctl_q.status;
      out_x_r  <= (ctl_q.status == ST_HIT) ? qx : '0;
      out_y_r  <= (ctl_q.status == ST_HIT) ? qy : '0;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.status  = out_st_r;
  assign out_ch.cross_x = out_x_r;
  assign out_ch.cross_y = out_y_r;

`ifndef SYNTH
  a_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_st_r != ST_HIT) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("point not cleared for non-hit status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_st_r == ST_NONE || out_st_r == ST_HIT || out_st_r == ST_A_PT ||
                   out_st_r == ST_C_PT || out_st_r == ST_EQUAL))
    else $error("status out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_vld_r && !v1_r && !v5_r))
    else $error("valid bits not cleared by reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ch.ready) |=> (out_vld_r && $stable(out_st_r) && $stable(v5_r)))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
